// ===== design/kl_pkg.sv =====
// kl_pkg: constants, token codes, keyword table and shared structs of the
// keyword lexer. No dependencies.
`default_nettype none

package kl_pkg;

   localparam int MAX_WORD = 32;
   localparam int IDX_W    = $clog2(MAX_WORD);
   localparam int CNT_W    = $clog2(MAX_WORD + 1);
   localparam int ADDR_W   = IDX_W + 1;
   localparam int KW_NUM   = 7;
   localparam int KW_SLOT  = 8;

   localparam logic [4:0] TOK_NUMBER = 5'd7;
   localparam logic [4:0] TOK_IDENT  = 5'd8;
   localparam logic [4:0] TOK_LPAREN = 5'd9;
   localparam logic [4:0] TOK_RPAREN = 5'd10;
   localparam logic [4:0] TOK_SEMI   = 5'd11;
   localparam logic [4:0] TOK_COMMA  = 5'd12;
   localparam logic [4:0] TOK_LBRACE = 5'd13;
   localparam logic [4:0] TOK_RBRACE = 5'd14;
   localparam logic [4:0] TOK_ASSIGN = 5'd15;
   localparam logic [4:0] TOK_GT     = 5'd16;
   localparam logic [4:0] TOK_LT     = 5'd17;
   localparam logic [4:0] TOK_PLUS   = 5'd18;
   localparam logic [4:0] TOK_STAR   = 5'd19;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // INT CHAR IF THEN ELSE WHILE RETURN
   localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd4, 3'd2, 3'd4, 3'd4, 3'd5, 3'd6};
   localparam logic [7:0] KW_TEXT [KW_NUM][KW_SLOT] = '{
      '{8'h49, 8'h4E, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h43, 8'h48, 8'h41, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h49, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h54, 8'h48, 8'h45, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h45, 8'h4C, 8'h53, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h57, 8'h48, 8'h49, 8'h4C, 8'h45, 8'h00, 8'h00, 8'h00},
      '{8'h52, 8'h45, 8'h54, 8'h55, 8'h52, 8'h4E, 8'h00, 8'h00}
   };

   typedef struct packed {
      logic       hit;
      logic [4:0] kind;
   } punct_type;

   typedef struct packed {
      logic             has_word;
      logic [4:0]       word_kind;
      logic [31:0]      number;
      logic             ovf;
      logic             cut;
      logic [CNT_W-1:0] len;
      logic             bank;
      logic             has_punct;
      logic [4:0]       punct_kind;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

   typedef struct packed {
      logic streaming;
      logic bank;
   } bstat_type;

   function automatic punct_type punct_lookup(input logic [7:0] c);
      punct_type p;
      p.hit  = 1'b1;
      p.kind = TOK_LPAREN;
      case (c)
         8'h28:   p.kind = TOK_LPAREN;
         8'h29:   p.kind = TOK_RPAREN;
         8'h3B:   p.kind = TOK_SEMI;
         8'h2C:   p.kind = TOK_COMMA;
         8'h7B:   p.kind = TOK_LBRACE;
         8'h7D:   p.kind = TOK_RBRACE;
         8'h3D:   p.kind = TOK_ASSIGN;
         8'h3E:   p.kind = TOK_GT;
         8'h3C:   p.kind = TOK_LT;
         8'h2B:   p.kind = TOK_PLUS;
         8'h2A:   p.kind = TOK_STAR;
         default: p.hit  = 1'b0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== design/keyword_lexer.sv =====
// keyword_lexer: top level; front, command queue and back joined together.
// Uses kl_pkg, kl_front, kl_queue, kl_back.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_in_char
//   rsp     | out       | rsp_valid/rsp_stall  | token, value, char, length, flags
//
// A delimiter pushes at most one command (word, punctuation or both).
// The back pops each command in its idle state, then emits a keyword, number
// or punctuation result from its own state and each identifier character
// through a read state (registered read of the word memory) and a send state.
// The word memory has two banks; the front stalls while the bank it would
// fill is still busy with an identifier, or while the two-entry queue is full.
// Synchronous reset clears control state only; no clearing pass.
`default_nettype none

module keyword_lexer
   import kl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_char,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [4:0]       rsp_token_kind,
   output logic [31:0]      rsp_number_value,
   output logic [7:0]       rsp_ident_char,
   output logic [5:0]       rsp_ident_length,
   output logic             rsp_run_last,
   output logic             rsp_word_cut,
   output logic             rsp_number_overflow
);

   logic      q_full;
   logic      q_empty;
   logic      q_push;
   logic      q_pop;
   cmd_type   q_data;
   cmd_type   q_head;
   wr_type    wr;
   done_type  done;
   bstat_type stat;

   kl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_char (req_in_char),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data),
      .wr          (wr),
      .done        (done)
   );

   kl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   kl_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .wr                  (wr),
      .done                (done),
      .stat                (stat),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_token_kind      (rsp_token_kind),
      .rsp_number_value    (rsp_number_value),
      .rsp_ident_char      (rsp_ident_char),
      .rsp_ident_length    (rsp_ident_length),
      .rsp_run_last        (rsp_run_last),
      .rsp_word_cut        (rsp_word_cut),
      .rsp_number_overflow (rsp_number_overflow)
   );

`ifndef SYNTH
   a_no_write_streaming_bank: assert property (@(posedge clock) disable iff (reset)
      !(wr.en && stat.streaming && wr.addr[ADDR_W-1] == stat.bank))
      else $error("word write into bank being streamed");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (!q_full || q_pop))
      else $error("command pushed into full queue");

   a_done_while_streaming: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> stat.streaming && done.bank == stat.bank)
      else $error("bank release outside identifier stream");

   a_non_ident_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind != TOK_IDENT) |->
         (rsp_ident_char == 8'd0 && rsp_ident_length == 6'd0))
      else $error("identifier fields set on non-identifier token");
`endif

endmodule

`default_nettype wire

// ===== design/kl_front.sv =====
// kl_front: takes characters, builds the current word (number value, keyword
// match) and pushes flush commands. Uses kl_pkg; writes the back's word memory.
`default_nettype none

module kl_front
   import kl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_char,
   input  wire logic        q_full,
   output logic             q_push,
   output cmd_type          q_data,
   output wr_type           wr,
   input  wire done_type    done
);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       acc_ff, acc_in;
   logic              digits_ff, digits_in;
   logic              ovf_ff, ovf_in;
   logic              cut_ff, cut_in;
   logic              first_digit_ff, first_digit_in;
   logic [KW_NUM-1:0] match_ff, match_in;
   logic              bank_ff, bank_in;
   logic [1:0]        busy_ff, busy_in;

   logic        accept;
   logic        blank;
   logic        digit;
   punct_type   pl;
   logic [35:0] acc10;
   logic        kw_found;
   logic [4:0]  kw_kind;

   assign req_stall = q_full || busy_ff[bank_ff];
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pl     = punct_lookup(req_in_char);
      blank  = (req_in_char == CH_NUL) || (req_in_char == CH_TAB) ||
               (req_in_char == CH_LF)  || (req_in_char == CH_SPACE);
      digit  = (req_in_char >= CH_ZERO) && (req_in_char <= CH_NINE);
      acc10  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
               {32'd0, req_in_char[3:0]};
      kw_found = 1'b0;
      kw_kind  = 5'd0;
      for (int i = 0; i < KW_NUM; i++) begin
         if (!kw_found && match_ff[i] && count_ff == CNT_W'(KW_LEN[i])) begin
            kw_found = 1'b1;
            kw_kind  = 5'(i);
         end
      end
   end

   always_comb begin
      count_in       = count_ff;
      acc_in         = acc_ff;
      digits_in      = digits_ff;
      ovf_in         = ovf_ff;
      cut_in         = cut_ff;
      first_digit_in = first_digit_ff;
      match_in       = match_ff;
      bank_in        = bank_ff;
      busy_in        = busy_ff;
      if (done.valid) begin
         busy_in[done.bank] = 1'b0;
      end
      wr.en   = 1'b0;
      wr.addr = {bank_ff, count_ff[IDX_W-1:0]};
      wr.data = req_in_char;
      q_push  = 1'b0;
      q_data.has_word   = count_ff != '0;
      q_data.word_kind  = kw_found ? kw_kind : (first_digit_ff ? TOK_NUMBER : TOK_IDENT);
      q_data.number     = (!kw_found && first_digit_ff) ? acc_ff : 32'd0;
      q_data.ovf        = !kw_found && first_digit_ff && ovf_ff;
      q_data.cut        = cut_ff;
      q_data.len        = count_ff;
      q_data.bank       = bank_ff;
      q_data.has_punct  = pl.hit;
      q_data.punct_kind = pl.kind;

      if (accept) begin
         if (!pl.hit && !blank) begin
            if (count_ff >= CNT_W'(MAX_WORD)) begin
               cut_in = 1'b1;
            end else begin
               wr.en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (count_ff == '0) begin
                  digits_in      = digit;
                  first_digit_in = digit;
                  acc_in         = digit ? {28'd0, req_in_char[3:0]} : 32'd0;
               end else if (digits_ff) begin
                  if (digit) begin
                     acc_in = acc10[31:0];
                     if (acc10[35:32] != 4'd0) begin
                        ovf_in = 1'b1;
                     end
                  end else begin
                     digits_in = 1'b0;
                  end
               end
               for (int i = 0; i < KW_NUM; i++) begin
                  match_in[i] = (count_ff == '0 || match_ff[i]) &&
                                (count_ff < CNT_W'(KW_LEN[i])) &&
                                (KW_TEXT[i][count_ff[2:0]] == req_in_char);
               end
            end
         end else begin
            q_push = q_data.has_word || pl.hit;
            if (q_data.has_word && q_data.word_kind == TOK_IDENT) begin
               busy_in[bank_ff] = 1'b1;
               bank_in          = !bank_ff;
            end
            count_in       = '0;
            acc_in         = 32'd0;
            digits_in      = 1'b0;
            ovf_in         = 1'b0;
            cut_in         = 1'b0;
            first_digit_in = 1'b0;
            match_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         acc_ff         <= 32'd0;
         digits_ff      <= 1'b0;
         ovf_ff         <= 1'b0;
         cut_ff         <= 1'b0;
         first_digit_ff <= 1'b0;
         match_ff       <= '0;
         bank_ff        <= 1'b0;
         busy_ff        <= 2'b00;
      end else begin
         count_ff       <= count_in;
         acc_ff         <= acc_in;
         digits_ff      <= digits_in;
         ovf_ff         <= ovf_in;
         cut_ff         <= cut_in;
         first_digit_ff <= first_digit_in;
         match_ff       <= match_in;
         bank_ff        <= bank_in;
         busy_ff        <= busy_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/kl_queue.sv =====
// kl_queue: two-entry command queue between front and back.
// Uses kl_pkg for the command struct.
`default_nettype none

module kl_queue
   import kl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   input  wire logic    pop,
   output logic         full,
   output logic         empty,
   output cmd_type      head
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/kl_back.sv =====
// kl_back: pops flush commands and emits tokens; holds the two-bank word
// memory and streams identifier characters from it. Uses kl_pkg.
`default_nettype none

module kl_back
   import kl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire cmd_type q_head,
   output logic         q_pop,
   input  wire wr_type  wr,
   output done_type     done,
   output bstat_type    stat,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [4:0]   rsp_token_kind,
   output logic [31:0]  rsp_number_value,
   output logic [7:0]   rsp_ident_char,
   output logic [5:0]   rsp_ident_length,
   output logic         rsp_run_last,
   output logic         rsp_word_cut,
   output logic         rsp_number_overflow
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WORD  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_IDENT = 5'b01000,
      ST_PUNCT = 5'b10000
   } state_type;

   logic [7:0] mem [2**ADDR_W];
   logic [7:0] rd_data_ff;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [4:0]       kind_ff, kind_in;
   logic [31:0]      num_ff, num_in;
   logic [7:0]       ch_ff, ch_in;
   logic [5:0]       len_ff, len_in;
   logic             last_ff, last_in;
   logic             cut_ff, cut_in;
   logic             ovf_ff, ovf_in;

   logic free;
   logic idx_last;

   assign free     = !valid_ff || !rsp_stall;
   assign idx_last = CNT_W'(idx_ff) == cmd_ff.len - 1'b1;
   assign stat.streaming = (state_ff == ST_READ) || (state_ff == ST_IDENT);
   assign stat.bank      = cmd_ff.bank;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      valid_in = free ? 1'b0 : valid_ff;
      kind_in  = kind_ff;
      num_in   = num_ff;
      ch_in    = ch_ff;
      len_in   = len_ff;
      last_in  = last_ff;
      cut_in   = cut_ff;
      ovf_in   = ovf_ff;
      q_pop      = 1'b0;
      done.valid = 1'b0;
      done.bank  = cmd_ff.bank;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               idx_in = '0;
               if (!q_head.has_word) begin
                  state_in = ST_PUNCT;
               end else if (q_head.word_kind == TOK_IDENT) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_WORD;
               end
            end
         end
         ST_WORD: begin
            if (free) begin
               valid_in = 1'b1;
               kind_in  = cmd_ff.word_kind;
               num_in   = cmd_ff.number;
               ch_in    = 8'd0;
               len_in   = 6'd0;
               last_in  = !cmd_ff.has_punct;
               cut_in   = cmd_ff.cut;
               ovf_in   = cmd_ff.ovf;
               state_in = cmd_ff.has_punct ? ST_PUNCT : ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_IDENT;
         end
         ST_IDENT: begin
            if (free) begin
               valid_in = 1'b1;
               kind_in  = TOK_IDENT;
               num_in   = 32'd0;
               ch_in    = rd_data_ff;
               len_in   = 6'(cmd_ff.len);
               last_in  = idx_last && !cmd_ff.has_punct;
               cut_in   = cmd_ff.cut;
               ovf_in   = 1'b0;
               if (idx_last) begin
                  done.valid = 1'b1;
                  state_in   = cmd_ff.has_punct ? ST_PUNCT : ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_PUNCT: begin
            if (free) begin
               valid_in = 1'b1;
               kind_in  = cmd_ff.punct_kind;
               num_in   = 32'd0;
               ch_in    = 8'd0;
               len_in   = 6'd0;
               last_in  = 1'b1;
               cut_in   = 1'b0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[{cmd_ff.bank, idx_ff}];
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      kind_ff <= kind_in;
      num_ff  <= num_in;
      ch_ff   <= ch_in;
      len_ff  <= len_in;
      last_ff <= last_in;
      cut_ff  <= cut_in;
      ovf_ff  <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_token_kind      = kind_ff;
   assign rsp_number_value    = num_ff;
   assign rsp_ident_char      = ch_ff;
   assign rsp_ident_length    = len_ff;
   assign rsp_run_last        = last_ff;
   assign rsp_word_cut        = cut_ff;
   assign rsp_number_overflow = ovf_ff;

endmodule

`default_nettype wire
